/* hw/rtl/framed_packet_parser_crc8_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_CRC8_DEFINES_SVH
`define FRAMED_PACKET_PARSER_CRC8_DEFINES_SVH

`ifndef SYNTHESIS
// The expression must never be true outside reset.
`define FPP_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");
// When the antecedent holds, the consequent holds in the same cycle.
`define FPP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");
// When the antecedent holds, the consequent holds in the next cycle.
`define FPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");
`else
`define FPP_ASSERT_NEVER(label, expr)
`define FPP_ASSERT_IMPL(label, ante, cons)
`define FPP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/fpp_pkg.sv */
// ----------------------------------------------------------------------------
// Framed packet parser package
// Shared sizes, register indexes, descriptor types and the CRC-8 step.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // Payload bytes one frame buffer holds.
  localparam int PAYLOAD_DEPTH = 32;
  localparam int PL_AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int FILL_W = PL_AW + 1;

  // Frames that may wait between parser and emitter; one buffer bank each.
  localparam int FIFO_DEPTH = 2;
  localparam int FQ_AW = $clog2(FIFO_DEPTH);
  localparam int FQ_CW = FQ_AW + 1;
  localparam int BUF_AW = FQ_AW + PL_AW;
  localparam int BUF_ENTRIES = 1 << BUF_AW;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SYNC_FIRST = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_EXPECTED_VERSION = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] EXPECTED_VERSION_RST = 8'h01;
  localparam logic [6:0] MAX_PAYLOAD_RST = 7'd32;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] CRC_MSB = 8'h80;

  typedef struct packed {
    logic [7:0] seq;
    logic [7:0] ftype;
    logic [6:0] length;
    logic [FQ_AW-1:0] bank;
  } frame_desc_t;

  typedef struct packed {
    logic en;
    logic [BUF_AW-1:0] addr;
    logic [7:0] data;
  } buf_wr_t;

  // One byte through the MSB-first CRC-8.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/framed_packet_parser_crc8.sv */
// ----------------------------------------------------------------------------
// Framed packet parser with CRC-8 check
// Finds sync-delimited frames in a byte stream and emits checked payloads.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Transaction contents
//   --------  ---------  --------------------  ---------------------------------
//   cfg       in         cfg_we                cfg_index, cfg_data
//   in        in         in_valid / in_stall   rx_byte
//   out       out        out_valid / out_stall seq_number .. last (one result)
//
// The parser takes one received byte per cycle while the descriptor queue has
// room, and stalls input once two checked frames hold both payload banks.
// Each result passes through two emitter steps: a registered payload memory
// read, then the output register load; a new read is not issued until the
// previous one has been loaded. Reset is synchronous and active high; it
// restores the register defaults and returns the parser to sync hunting.
// ----------------------------------------------------------------------------
//
// Frame format: sync_first, sync_second, version, sequence, type, length,
// payload bytes, then a CRC-8 (polynomial 0x07, initial value zero) taken over
// version through payload. A wrong second sync byte or an oversized length
// returns the parser to hunting. A bad CRC or a version mismatch drops the
// frame silently. A good frame yields one result transaction per payload byte,
// or a single result transaction for an empty payload, with last set on the
// final one.
//
// The front end writes payload bytes into one of two banks of the payload
// memory and pushes a descriptor into a two-entry queue when the CRC and version check.
// The back end pops descriptors in order and reads the matching bank.

module framed_packet_parser_crc8
  import fpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] seq_number,
  output logic [7:0] frame_type,
  output logic [6:0] payload_length,
  output logic       has_payload,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_index,
  output logic       last
);

  buf_wr_t     buf_wr;
  frame_desc_t push_desc;
  frame_desc_t head;
  logic        push;
  logic        pop;
  logic        q_empty;
  logic        q_full;
  logic        accept;

  // A full queue means both banks belong to frames not yet played out.
  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  fpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .buf_wr    (buf_wr),
    .push      (push),
    .push_desc (push_desc)
  );

  fpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  fpp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .buf_wr         (buf_wr),
    .head           (head),
    .head_valid     (!q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .seq_number     (seq_number),
    .frame_type     (frame_type),
    .payload_length (payload_length),
    .has_payload    (has_payload),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last)
  );

endmodule

/* hw/rtl/fpp_queue.sv */
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Small register FIFO carrying accepted frame descriptors to the emitter.
// ----------------------------------------------------------------------------
`include "framed_packet_parser_crc8_defines.svh"

module fpp_queue
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t head,
  output logic        empty,
  output logic        full
);

  frame_desc_t entries [FIFO_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_CW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == FQ_CW'(FIFO_DEPTH));
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FQ_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FQ_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FPP_ASSERT_NEVER(a_push_when_full, push && full)
  `FPP_ASSERT_NEVER(a_pop_when_empty, pop && empty)

endmodule

/* hw/rtl/fpp_front.sv */
// ----------------------------------------------------------------------------
// Frame parser front end
// Hunts for sync, collects the header, stores payload and checks the CRC.
// ----------------------------------------------------------------------------
`include "framed_packet_parser_crc8_defines.svh"

module fpp_front
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output buf_wr_t     buf_wr,
  output logic        push,
  output frame_desc_t push_desc
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_VER = 3'd2;
  localparam logic [2:0] PH_SEQ = 3'd3;
  localparam logic [2:0] PH_TYPE = 3'd4;
  localparam logic [2:0] PH_LEN = 3'd5;
  localparam logic [2:0] PH_DATA = 3'd6;
  localparam logic [2:0] PH_CRC = 3'd7;

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] expected_version;
  logic [6:0] max_payload;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] held_version;
  logic [7:0] held_seq;
  logic [7:0] held_type;
  logic [6:0] held_length;
  logic [FILL_W-1:0] fill;
  logic [7:0] crc;
  logic [FQ_AW-1:0] bank;

  logic [7:0] crc_step;
  logic [6:0] limit;
  logic       len_ok;
  logic       frame_ok;
  logic [6:0] fill_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      expected_version <= EXPECTED_VERSION_RST;
      max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_FIRST:       sync_first <= cfg_data;
        REG_SYNC_SECOND:      sync_second <= cfg_data;
        REG_EXPECTED_VERSION: expected_version <= cfg_data;
        REG_MAX_PAYLOAD:      max_payload <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // The version byte restarts the CRC from its initial value.
  assign crc_step = crc8_update((phase == PH_VER) ? CRC_INIT : crc, rx_byte);
  assign limit = (max_payload > 7'(PAYLOAD_DEPTH)) ? 7'(PAYLOAD_DEPTH) : max_payload;
  assign len_ok = ({1'b0, limit} >= rx_byte);
  assign frame_ok = (rx_byte == crc) && (held_version == expected_version);
  assign fill_inc = 7'(fill) + 7'd1;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SYNC1: phase_next = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
      PH_SYNC2: phase_next = (rx_byte == sync_second) ? PH_VER : PH_SYNC1;
      PH_VER:   phase_next = PH_SEQ;
      PH_SEQ:   phase_next = PH_TYPE;
      PH_TYPE:  phase_next = PH_LEN;
      PH_LEN: begin
        if (!len_ok) begin
          phase_next = PH_SYNC1;
        end else begin
          phase_next = (rx_byte == 8'h00) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA:  phase_next = (fill_inc == held_length) ? PH_CRC : PH_DATA;
      PH_CRC:   phase_next = PH_SYNC1;
      default:  phase_next = PH_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
      bank <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (push) begin
        bank <= (bank == FQ_AW'(FIFO_DEPTH - 1)) ? '0 : bank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_VER: begin
          held_version <= rx_byte;
          crc <= crc_step;
        end
        PH_SEQ: begin
          held_seq <= rx_byte;
          crc <= crc_step;
        end
        PH_TYPE: begin
          held_type <= rx_byte;
          crc <= crc_step;
        end
        PH_LEN: begin
          held_length <= rx_byte[6:0];
          crc <= crc_step;
          fill <= '0;
        end
        PH_DATA: begin
          fill <= fill + 1'b1;
          crc <= crc_step;
        end
        default: begin
        end
      endcase
    end
  end

  assign buf_wr.en = accept && (phase == PH_DATA);
  assign buf_wr.addr = {bank, fill[PL_AW-1:0]};
  assign buf_wr.data = rx_byte;

  assign push = accept && (phase == PH_CRC) && frame_ok;
  assign push_desc.seq = held_seq;
  assign push_desc.ftype = held_type;
  assign push_desc.length = held_length;
  assign push_desc.bank = bank;

  `FPP_ASSERT_NEXT(a_push_back_to_hunt, push, phase == PH_SYNC1)
  `FPP_ASSERT_IMPL(a_data_fill_range, phase == PH_DATA,
                   fill < FILL_W'(PAYLOAD_DEPTH))

endmodule

/* hw/rtl/fpp_back.sv */
// ----------------------------------------------------------------------------
// Frame emitter back end
// Owns the banked payload memory and plays queued frames out as results.
// ----------------------------------------------------------------------------
`include "framed_packet_parser_crc8_defines.svh"

module fpp_back
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  buf_wr_t     buf_wr,
  input  frame_desc_t head,
  input  logic        head_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  seq_number,
  output logic [7:0]  frame_type,
  output logic [6:0]  payload_length,
  output logic        has_payload,
  output logic [7:0]  payload_byte,
  output logic [5:0]  byte_index,
  output logic        last
);

  logic [7:0] mem [BUF_ENTRIES];
  logic [7:0] rd_data;
  logic [PL_AW-1:0] idx;
  logic rd_pend;
  logic issue;
  logic empty_frame;
  logic final_res;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
  end

  // A read is issued only when the output slot is free by the time data returns.
  assign issue = head_valid && !rd_pend && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[{head.bank, idx}];
    end
  end

  assign empty_frame = (head.length == 7'd0);
  assign final_res = empty_frame || ((7'(idx) + 7'd1) == head.length);
  assign pop = rd_pend && final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end
      if (rd_pend) begin
        rd_pend <= 1'b0;
        out_valid <= 1'b1;
        idx <= final_res ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      seq_number <= head.seq;
      frame_type <= head.ftype;
      payload_length <= head.length;
      has_payload <= !empty_frame;
      payload_byte <= empty_frame ? 8'h00 : rd_data;
      byte_index <= empty_frame ? 6'd0 : 6'(idx);
      last <= final_res;
    end
  end

  `FPP_ASSERT_IMPL(a_slot_free_on_return, rd_pend, !out_valid)
  `FPP_ASSERT_IMPL(a_return_needs_frame, rd_pend, head_valid)

endmodule
